// ===== rtl/scg_pkg.sv =====
// scg_pkg: shared types and constants for the stepped clock generator
// word layouts, register indexes and register reset values
// no dependencies
`default_nettype none

package scg_pkg;

    localparam int NUM_MODES = 5;
    localparam int MODE_W    = 3;
    localparam int LED_W     = 5;
    localparam int NUM_PER   = 4;

    localparam logic [MODE_W-1:0] STEP_MODE = MODE_W'(NUM_MODES - 1);

    localparam int DIV_W   = 11;
    localparam int PCNT_W  = 10;
    localparam int PER_W   = 16;
    localparam int PULSE_W = 8;
    localparam int HOLD_W  = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_DIV = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_HOLD    = 3'd6;

    localparam logic [DIV_W-1:0]   DIV_MAX         = 11'd1024;
    localparam logic [DIV_W-1:0]   RST_PRESCALE    = 11'd1024;
    localparam logic [PER_W-1:0]   RST_PERIOD_0    = 16'd977;
    localparam logic [PER_W-1:0]   RST_PERIOD_1    = 16'd1465;
    localparam logic [PER_W-1:0]   RST_PERIOD_2    = 16'd1953;
    localparam logic [PER_W-1:0]   RST_PERIOD_3    = 16'd2441;
    localparam logic [PULSE_W-1:0] RST_PULSE_WIDTH = 8'd20;
    localparam logic [HOLD_W-1:0]  RST_STEP_HOLD   = 20'd500000;

    // input word, lowest bit first: toggle_press, select_press, step_press, pad
    typedef struct packed {
        logic [4:0] pad;
        logic       step_press;
        logic       select_press;
        logic       toggle_press;
    } in_word_t;

    // output word, lowest bit first: clock_out, pulse_out, mode_leds, running
    typedef struct packed {
        logic             running;
        logic [LED_W-1:0] mode_leds;
        logic             pulse_out;
        logic             clock_out;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/stepped_clock_generator.sv =====
// stepped_clock_generator: slow clock generator with run, mode select and manual step
// uses scg_pkg for word layouts, register indexes and reset values
`default_nettype none

// One input word stands for one base clock cycle and carries the three button
// flags; one output word comes back per input word with the clock level, the
// pulse, the one-hot mode leds and the run flag. All state is updated from the
// accepted word, and the result is held in one output register, so a word is
// taken every cycle while the output side is ready. Registers are written
// through the cfg port, which is always ready, and should only be written while
// no word is in flight.
module stepped_clock_generator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [scg_pkg::IN_DATA_W-1:0]     s_tdata,   // toggle_press, select_press, step_press
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [scg_pkg::OUT_DATA_W-1:0]         m_tdata,   // clock_out, pulse_out, mode_leds[4:0], running
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [scg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [scg_pkg::DIV_W-1:0]   div_reg;
    logic [scg_pkg::PER_W-1:0]   period_reg [scg_pkg::NUM_PER];
    logic [scg_pkg::PULSE_W-1:0] pwidth_reg;
    logic [scg_pkg::HOLD_W-1:0]  shold_reg;

    logic [scg_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic                        run_reg, run_next;
    logic [scg_pkg::PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [scg_pkg::PER_W-1:0]   tick_reg, tick_next;
    logic                        level_reg, level_next;
    logic [scg_pkg::PULSE_W-1:0] pulse_reg, pulse_next;
    logic [scg_pkg::HOLD_W-1:0]  hold_reg, hold_next;

    logic                        out_valid_reg;
    scg_pkg::out_word_t          out_reg, out_next;

    scg_pkg::in_word_t           in_word;
    logic                        accept;
    logic                        step_fire;
    logic [scg_pkg::DIV_W-1:0]   eff_div;
    logic [scg_pkg::PULSE_W-1:0] eff_pulse;
    logic [scg_pkg::HOLD_W-1:0]  eff_hold;
    logic [scg_pkg::PER_W-1:0]   sel_period;
    logic [scg_pkg::MODE_W:0]    mode_inc;

    assign in_word   = scg_pkg::in_word_t'(s_tdata);
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        if (div_reg == '0)
            eff_div = scg_pkg::DIV_W'(1);
        else if (div_reg > scg_pkg::DIV_MAX)
            eff_div = scg_pkg::DIV_MAX;
        else
            eff_div = div_reg;
        eff_pulse = (pwidth_reg == '0) ? scg_pkg::PULSE_W'(1) : pwidth_reg;
        eff_hold  = (shold_reg == '0) ? scg_pkg::HOLD_W'(1) : shold_reg;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        run_next   = run_reg;
        pcnt_next  = pcnt_reg;
        tick_next  = tick_reg;
        level_next = level_reg;
        pulse_next = (pulse_reg != '0) ? pulse_reg - scg_pkg::PULSE_W'(1) : pulse_reg;
        hold_next  = (hold_reg != '0) ? hold_reg - scg_pkg::HOLD_W'(1) : hold_reg;

        if (in_word.toggle_press && mode_reg != scg_pkg::STEP_MODE)
        begin
            run_next   = !run_reg;
            level_next = 1'b0;
            if (!run_reg)
                hold_next = '0;
        end

        step_fire = in_word.step_press && !run_next && mode_reg == scg_pkg::STEP_MODE
                    && hold_next == '0;

        mode_inc = {1'b0, mode_reg} + (scg_pkg::MODE_W + 1)'(1);
        if (in_word.select_press && !run_next)
        begin
            if (mode_inc >= (scg_pkg::MODE_W + 1)'(scg_pkg::NUM_MODES))
                mode_next = '0;
            else
                mode_next = mode_inc[scg_pkg::MODE_W-1:0];
        end

        if (step_fire)
        begin
            hold_next  = eff_hold;
            pulse_next = eff_pulse;
        end

        if (mode_next < scg_pkg::MODE_W'(scg_pkg::NUM_PER))
            sel_period = period_reg[mode_next[1:0]];
        else
            sel_period = period_reg[scg_pkg::NUM_PER-1];

        if (run_next)
        begin
            if ({1'b0, pcnt_reg} + scg_pkg::DIV_W'(1) >= eff_div)
            begin
                pcnt_next = '0;
                if (tick_reg == sel_period)
                begin
                    tick_next  = '0;
                    level_next = !level_next;
                    pulse_next = eff_pulse;
                end
                else
                begin
                    tick_next = tick_reg + scg_pkg::PER_W'(1);
                end
            end
            else
            begin
                pcnt_next = pcnt_reg + scg_pkg::PCNT_W'(1);
            end
        end
        else
        begin
            level_next = (hold_next != '0);
        end

        out_next.clock_out = level_next;
        out_next.pulse_out = (pulse_next != '0);
        out_next.running   = run_next;
        if (mode_next < scg_pkg::MODE_W'(scg_pkg::LED_W))
            out_next.mode_leds = scg_pkg::LED_W'(1) << mode_next;
        else
            out_next.mode_leds = '0;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= scg_pkg::RST_PRESCALE;
            period_reg[0] <= scg_pkg::RST_PERIOD_0;
            period_reg[1] <= scg_pkg::RST_PERIOD_1;
            period_reg[2] <= scg_pkg::RST_PERIOD_2;
            period_reg[3] <= scg_pkg::RST_PERIOD_3;
            pwidth_reg    <= scg_pkg::RST_PULSE_WIDTH;
            shold_reg     <= scg_pkg::RST_STEP_HOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scg_pkg::REG_PRESCALE_DIV: div_reg       <= cfg_data[scg_pkg::DIV_W-1:0];
                scg_pkg::REG_PERIOD_0:     period_reg[0] <= cfg_data[scg_pkg::PER_W-1:0];
                scg_pkg::REG_PERIOD_1:     period_reg[1] <= cfg_data[scg_pkg::PER_W-1:0];
                scg_pkg::REG_PERIOD_2:     period_reg[2] <= cfg_data[scg_pkg::PER_W-1:0];
                scg_pkg::REG_PERIOD_3:     period_reg[3] <= cfg_data[scg_pkg::PER_W-1:0];
                scg_pkg::REG_PULSE_WIDTH:  pwidth_reg    <= cfg_data[scg_pkg::PULSE_W-1:0];
                scg_pkg::REG_STEP_HOLD:    shold_reg     <= cfg_data[scg_pkg::HOLD_W-1:0];
                default:                   ;
            endcase
        end
    end

    // generator state, advanced once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            run_reg   <= 1'b0;
            pcnt_reg  <= '0;
            tick_reg  <= '0;
            level_reg <= 1'b0;
            pulse_reg <= '0;
            hold_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            pcnt_reg  <= pcnt_next;
            tick_reg  <= tick_next;
            level_reg <= level_next;
            pulse_reg <= pulse_next;
            hold_reg  <= hold_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

`ifndef SYNTH
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg < scg_pkg::MODE_W'(scg_pkg::NUM_MODES))
        else $error("mode out of range");

    a_no_hold_running: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> hold_reg == '0)
        else $error("hold active while running");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(mode_reg) && $stable(run_reg) && $stable(hold_reg)
                    && $stable(pulse_reg))
        else $error("state moved without an accepted word");

    a_run_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.running == run_reg)
        else $error("running flag out of step with state");

    a_stopped_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !run_reg) |-> out_reg.clock_out == (hold_reg != '0))
        else $error("stopped clock level disagrees with hold");
`endif

endmodule

`default_nettype wire
